// ----- hw/rtl/dlmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Debounced LED mode controller package
// Shared types, register indexes and reset values of the configuration space.
// ----------------------------------------------------------------------------
package dlmc_pkg;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_BREATHE = 2'd3
    } mode_t;

    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 8;

    typedef logic [1:0]            cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [STEP_W-1:0]     step_t;

    localparam cfg_index_t REG_DEBOUNCE_TICKS   = 2'd0;
    localparam cfg_index_t REG_BLINK_HALF_TICKS = 2'd1;
    localparam cfg_index_t REG_BREATHE_INTERVAL = 2'd2;
    localparam cfg_index_t REG_BREATHE_STEP     = 2'd3;

    localparam cfg_data_t RST_DEBOUNCE_TICKS   = 16'd10;
    localparam cfg_data_t RST_BLINK_HALF_TICKS = 16'd500;
    localparam cfg_data_t RST_BREATHE_INTERVAL = 16'd10;
    localparam step_t     RST_BREATHE_STEP     = 8'd5;

endpackage
`default_nettype wire

// ----- hw/rtl/dlmc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Debounced LED mode controller channels
// Tick channel carrying the raw button sample and LED channel carrying results.
// ----------------------------------------------------------------------------
interface dlmc_tick_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface dlmc_led_if #(
    parameter int DUTY_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           led_mode;
    logic                 led1_pwm_active;
    logic [DUTY_BITS-1:0] led1_duty;
    logic                 led1_level;
    logic                 led2_level;

    modport source (
        output valid, output led_mode, output led1_pwm_active, output led1_duty,
        output led1_level, output led2_level, input ready
    );
    modport sink (
        input valid, input led_mode, input led1_pwm_active, input led1_duty,
        input led1_level, input led2_level, output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/debounced_led_mode_controller_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Debounced LED mode controller
// Debounces an active-low button and steps LEDs through off, on, blink and
// breathe modes, one tick word in and one LED word out.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the tick channel is one timer tick carrying the raw button
// sample (1 released, 0 pressed). For every accepted tick word the block
// returns exactly one word on the LED channel with the mode, the breathe duty
// and the digital LED levels after that tick's update.
// The whole update is one pass of counter and compare logic, so a tick word
// is taken every cycle while tick ready is high; its LED word is registered.
// A two-entry output stage (result register plus skid register) keeps the
// tick channel open for one more word while the receiver stalls; tick ready
// drops only once both entries are full.
// Reset puts the block in off mode with the button released, clears all
// timers and loads the default configuration. Configuration writes take
// effect at once and are meant to happen while no word is in flight.
// ----------------------------------------------------------------------------
module debounced_led_mode_controller_top #(
    parameter int COUNTER_WIDTH = 16,
    parameter int DUTY_BITS     = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire dlmc_pkg::cfg_index_t cfg_index,
    input  wire dlmc_pkg::cfg_data_t  cfg_wdata,
    dlmc_tick_if.sink                 tick,
    dlmc_led_if.source                led
);
    import dlmc_pkg::*;

    localparam int CW   = COUNTER_WIDTH;
    localparam int CMPW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int SW   = ((DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W) + 1;
    localparam logic [CW-1:0]        CNT_MAX  = {CW{1'b1}};
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    // Configuration registers.
    cfg_data_t debounce_reg;
    cfg_data_t blink_half_reg;
    cfg_data_t breathe_intv_reg;
    step_t     breathe_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= RST_DEBOUNCE_TICKS;
            blink_half_reg   <= RST_BLINK_HALF_TICKS;
            breathe_intv_reg <= RST_BREATHE_INTERVAL;
            breathe_step_reg <= RST_BREATHE_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_reg     <= cfg_wdata;
                REG_BLINK_HALF_TICKS: blink_half_reg   <= cfg_wdata;
                REG_BREATHE_INTERVAL: breathe_intv_reg <= cfg_wdata;
                REG_BREATHE_STEP:     breathe_step_reg <= cfg_wdata[STEP_W-1:0];
                default:              ;
            endcase
        end
    end

    // Controller state.
    mode_t                mode_reg,          mode_next;
    logic                 last_sample_reg,   last_sample_next;
    logic [CW-1:0]        stable_count_reg,  stable_count_next;
    logic                 accepted_reg,      accepted_next;
    logic [CW-1:0]        blink_count_reg,   blink_count_next;
    logic                 blink_phase_reg,   blink_phase_next;
    logic [CW-1:0]        breathe_count_reg, breathe_count_next;
    logic [DUTY_BITS-1:0] duty_reg,          duty_next;
    logic                 ramp_down_reg,     ramp_down_next;
    logic                 led2_hold_reg,     led2_hold_next;

    logic                 level_ok;
    logic                 entered;
    logic [CW-1:0]        blink_base;
    logic [CW-1:0]        breathe_base;
    logic [DUTY_BITS-1:0] duty_base;
    logic                 ramp_base;
    logic [SW-1:0]        up_sum;
    logic [SW-1:0]        dn_diff;
    logic                 hit_top;
    logic                 hit_bottom;

    logic                 res_pwm;
    logic [DUTY_BITS-1:0] res_duty;
    logic                 res_led1;

    always_comb
    begin
        last_sample_next  = tick.button_level;
        stable_count_next = (tick.button_level != last_sample_reg) ? '0 :
                            (stable_count_reg == CNT_MAX) ? CNT_MAX :
                            stable_count_reg + 1'b1;
        level_ok          = CMPW'(stable_count_next) > CMPW'(debounce_reg);
        entered           = level_ok && !tick.button_level && accepted_reg;
        accepted_next     = level_ok ? tick.button_level : accepted_reg;
        mode_next         = entered ? mode_t'(mode_reg + 2'd1) : mode_reg;

        blink_count_next   = blink_count_reg;
        blink_phase_next   = blink_phase_reg;
        breathe_count_next = breathe_count_reg;
        duty_next          = duty_reg;
        ramp_down_next     = ramp_down_reg;
        led2_hold_next     = led2_hold_reg;

        blink_base   = entered ? '0 :
                       (blink_count_reg == CNT_MAX) ? CNT_MAX : blink_count_reg + 1'b1;
        breathe_base = entered ? '0 :
                       (breathe_count_reg == CNT_MAX) ? CNT_MAX : breathe_count_reg + 1'b1;
        duty_base    = entered ? '0 : duty_reg;
        ramp_base    = entered ? 1'b0 : ramp_down_reg;

        up_sum  = SW'(duty_base) + SW'(breathe_step_reg);
        dn_diff = SW'(duty_base) - SW'(breathe_step_reg);
        if (ramp_base)
        begin
            hit_top    = (breathe_step_reg == '0) && (duty_base == DUTY_MAX);
            hit_bottom = SW'(duty_base) <= SW'(breathe_step_reg);
        end
        else
        begin
            hit_top    = up_sum >= SW'(DUTY_MAX);
            hit_bottom = up_sum == '0;
        end

        unique case (mode_next)
            MODE_OFF:
            begin
                led2_hold_next = 1'b0;
            end
            MODE_ON:
            begin
                led2_hold_next = 1'b1;
            end
            MODE_BLINK:
            begin
                if (CMPW'(blink_base) >= CMPW'(blink_half_reg))
                begin
                    blink_count_next = '0;
                    blink_phase_next = entered ? 1'b1 : !blink_phase_reg;
                end
                else
                begin
                    blink_count_next = blink_base;
                    blink_phase_next = entered ? 1'b0 : blink_phase_reg;
                end
                led2_hold_next = blink_phase_next;
            end
            MODE_BREATHE:
            begin
                ramp_down_next = ramp_base;
                duty_next      = duty_base;
                if (CMPW'(breathe_base) >= CMPW'(breathe_intv_reg))
                begin
                    breathe_count_next = '0;
                    priority if (hit_top)
                    begin
                        duty_next      = DUTY_MAX;
                        ramp_down_next = !ramp_base;
                    end
                    else if (hit_bottom)
                    begin
                        duty_next      = '0;
                        ramp_down_next = !ramp_base;
                    end
                    else
                    begin
                        duty_next = ramp_base ? dn_diff[DUTY_BITS-1:0]
                                              : up_sum[DUTY_BITS-1:0];
                    end
                end
                else
                begin
                    breathe_count_next = breathe_base;
                end
            end
        endcase
    end

    always_comb
    begin
        unique case (mode_next)
            MODE_OFF:
            begin
                res_pwm  = 1'b0;
                res_duty = '0;
                res_led1 = 1'b0;
            end
            MODE_ON:
            begin
                res_pwm  = 1'b0;
                res_duty = '0;
                res_led1 = 1'b1;
            end
            MODE_BLINK:
            begin
                res_pwm  = 1'b0;
                res_duty = '0;
                res_led1 = blink_phase_next;
            end
            MODE_BREATHE:
            begin
                res_pwm  = 1'b1;
                res_duty = duty_next;
                res_led1 = 1'b0;
            end
        endcase
    end

    logic tick_fire;
    logic led_fire;

    assign tick_fire = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OFF;
            last_sample_reg   <= 1'b1;
            stable_count_reg  <= '0;
            accepted_reg      <= 1'b1;
            blink_count_reg   <= '0;
            blink_phase_reg   <= 1'b0;
            breathe_count_reg <= '0;
            duty_reg          <= '0;
            ramp_down_reg     <= 1'b0;
            led2_hold_reg     <= 1'b0;
        end
        else if (tick_fire)
        begin
            mode_reg          <= mode_next;
            last_sample_reg   <= last_sample_next;
            stable_count_reg  <= stable_count_next;
            accepted_reg      <= accepted_next;
            blink_count_reg   <= blink_count_next;
            blink_phase_reg   <= blink_phase_next;
            breathe_count_reg <= breathe_count_next;
            duty_reg          <= duty_next;
            ramp_down_reg     <= ramp_down_next;
            led2_hold_reg     <= led2_hold_next;
        end
    end

    // Output stage: result register backed by one skid entry.
    logic                 out_valid_reg;
    logic [1:0]           out_mode_reg;
    logic                 out_pwm_reg;
    logic [DUTY_BITS-1:0] out_duty_reg;
    logic                 out_led1_reg;
    logic                 out_led2_reg;

    logic                 skid_valid_reg;
    logic [1:0]           skid_mode_reg;
    logic                 skid_pwm_reg;
    logic [DUTY_BITS-1:0] skid_duty_reg;
    logic                 skid_led1_reg;
    logic                 skid_led2_reg;

    assign led_fire   = out_valid_reg && led.ready;
    assign tick.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (led_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (tick_fire)
        begin
            if (out_valid_reg && !led.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (led_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (led_fire)
            begin
                out_mode_reg <= skid_mode_reg;
                out_pwm_reg  <= skid_pwm_reg;
                out_duty_reg <= skid_duty_reg;
                out_led1_reg <= skid_led1_reg;
                out_led2_reg <= skid_led2_reg;
            end
        end
        else if (tick_fire)
        begin
            if (out_valid_reg && !led.ready)
            begin
                skid_mode_reg <= mode_next;
                skid_pwm_reg  <= res_pwm;
                skid_duty_reg <= res_duty;
                skid_led1_reg <= res_led1;
                skid_led2_reg <= led2_hold_next;
            end
            else
            begin
                out_mode_reg <= mode_next;
                out_pwm_reg  <= res_pwm;
                out_duty_reg <= res_duty;
                out_led1_reg <= res_led1;
                out_led2_reg <= led2_hold_next;
            end
        end
    end

    assign led.valid           = out_valid_reg;
    assign led.led_mode        = out_mode_reg;
    assign led.led1_pwm_active = out_pwm_reg;
    assign led.led1_duty       = out_duty_reg;
    assign led.led1_level      = out_led1_reg;
    assign led.led2_level      = out_led2_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb_debounced_led_mode_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced LED mode controller testbench
// Sends tick words with directed and randomly bounced button presses under
// several register settings, predicts every LED word in a tracker class and
// compares each returned word field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_debounced_led_mode_controller_top;
    import dlmc_pkg::*;

    localparam int DUTY_W = 8;
    localparam int DUTY_TOP = 255;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX = 10;
    localparam logic [21:0] PRESS_SCRIPT = 22'b1001100011000011001011;

    typedef struct packed {
        mode_t             mode;
        logic              pwm;
        logic [DUTY_W-1:0] duty;
        logic              led1;
        logic              led2;
    } led_word_t;

    class led_tracker;
        cfg_data_t         debounce = RST_DEBOUNCE_TICKS;
        cfg_data_t         blink_half = RST_BLINK_HALF_TICKS;
        cfg_data_t         breathe_interval = RST_BREATHE_INTERVAL;
        step_t             step = RST_BREATHE_STEP;
        mode_t             mode = MODE_OFF;
        logic              last_level = 1'b1;
        logic [15:0]       stable_cnt = '0;
        logic              held_level = 1'b1;
        logic [15:0]       blink_cnt = '0;
        logic              blink_phase = 1'b0;
        logic [15:0]       breathe_cnt = '0;
        logic [DUTY_W-1:0] duty = '0;
        logic              falling = 1'b0;
        logic              led2_hold = 1'b0;
        led_word_t         words_due[$];
        int                mismatches = 0;

        function void write_reg(cfg_index_t idx, cfg_data_t value);
            case (idx)
                REG_DEBOUNCE_TICKS:   debounce = value;
                REG_BLINK_HALF_TICKS: blink_half = value;
                REG_BREATHE_INTERVAL: breathe_interval = value;
                REG_BREATHE_STEP:     step = value[STEP_W-1:0];
                default:              ;
            endcase
        endfunction

        function void note_tick(logic level);
            led_word_t  w;
            logic       entered;
            logic [1:0] next_mode;
            int         next_duty;
            entered = 1'b0;
            if (level != last_level) stable_cnt = '0;
            else if (stable_cnt != 16'hFFFF) stable_cnt++;
            last_level = level;
            if (stable_cnt > debounce)
            begin
                if (!level && held_level)
                begin
                    next_mode = mode + 2'd1;
                    mode = mode_t'(next_mode);
                    entered = 1'b1;
                end
                held_level = level;
            end
            if (entered && mode == MODE_BLINK)
            begin
                blink_cnt = '0;
                blink_phase = 1'b0;
            end
            else if (entered && mode == MODE_BREATHE)
            begin
                breathe_cnt = '0;
                duty = '0;
                falling = 1'b0;
            end
            w.mode = mode;
            w.pwm = 1'b0;
            w.duty = '0;
            w.led1 = 1'b0;
            case (mode)
                MODE_OFF: led2_hold = 1'b0;
                MODE_ON:
                begin
                    w.led1 = 1'b1;
                    led2_hold = 1'b1;
                end
                MODE_BLINK:
                begin
                    if (!entered && blink_cnt != 16'hFFFF) blink_cnt++;
                    if (blink_cnt >= blink_half)
                    begin
                        blink_cnt = '0;
                        blink_phase = !blink_phase;
                    end
                    w.led1 = blink_phase;
                    led2_hold = blink_phase;
                end
                default:
                begin
                    if (!entered && breathe_cnt != 16'hFFFF) breathe_cnt++;
                    if (breathe_cnt >= breathe_interval)
                    begin
                        breathe_cnt = '0;
                        next_duty = falling ? int'(duty) - int'(step)
                                            : int'(duty) + int'(step);
                        if (next_duty >= DUTY_TOP)
                        begin
                            next_duty = DUTY_TOP;
                            falling = !falling;
                        end
                        else if (next_duty <= 0)
                        begin
                            next_duty = 0;
                            falling = !falling;
                        end
                        duty = DUTY_W'(next_duty);
                    end
                    w.pwm = 1'b1;
                    w.duty = duty;
                end
            endcase
            w.led2 = led2_hold;
            words_due.push_back(w);
        endfunction

        function void check_word(led_word_t got);
            led_word_t want;
            if (words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $write("%0t: LED word with none expected: ", $realtime);
                    $display("mode=%0d pwm=%0b duty=%0d led1=%0b led2=%0b",
                             got.mode, got.pwm, got.duty, got.led1, got.led2);
                end
                return;
            end
            want = words_due.pop_front();
            if (got.mode !== want.mode || got.pwm !== want.pwm || got.duty !== want.duty ||
                got.led1 !== want.led1 || got.led2 !== want.led2)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $write("%0t: LED word expected mode=%0d pwm=%0b duty=%0d led1=%0b led2=%0b",
                           $realtime, want.mode, want.pwm, want.duty, want.led1, want.led2);
                    $display(", got mode=%0d pwm=%0b duty=%0d led1=%0b led2=%0b",
                             got.mode, got.pwm, got.duty, got.led1, got.led2);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;
    logic       steady;
    int         phase_ticks;
    int         stall_cycles;
    led_word_t  seen;
    led_tracker tracker;

    dlmc_tick_if tick_ch ();
    dlmc_led_if #(.DUTY_BITS(DUTY_W)) led_ch ();

    debounced_led_mode_controller_top #(
        .COUNTER_WIDTH(16),
        .DUTY_BITS(DUTY_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .tick(tick_ch),
        .led(led_ch)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        led_ch.ready <= rst_n && (steady || $urandom_range(0, 99) >= 17);
    end

    always @(posedge clk)
    begin
        if (rst_n && led_ch.valid && led_ch.ready)
        begin
            seen.mode = mode_t'(led_ch.led_mode);
            seen.pwm = led_ch.led1_pwm_active;
            seen.duty = led_ch.led1_duty;
            seen.led1 = led_ch.led1_level;
            seen.led2 = led_ch.led2_level;
            tracker.check_word(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_tick(input logic level);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.button_level <= level;
        do @(posedge clk); while (!tick_ch.ready);
        tracker.note_tick(level);
        phase_ticks++;
        @(negedge clk);
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_tick(level);
    endtask

    task automatic drain_words;
        tick_ch.valid <= 1'b0;
        while (tracker.words_due.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        tracker.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic set_config(input cfg_data_t deb, input cfg_data_t blink,
                              input cfg_data_t breathe, input step_t stp);
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_BLINK_HALF_TICKS, blink);
        write_reg(REG_BREATHE_INTERVAL, breathe);
        write_reg(REG_BREATHE_STEP, cfg_data_t'(stp));
        cfg_we <= 1'b0;
    endtask

    // A press is a bounced run of low samples followed by a bounced run of high
    // samples; runs that fall short of the debounce time must not count.
    task automatic run_phase(input cfg_data_t deb, input cfg_data_t blink,
                             input cfg_data_t breathe, input step_t stp,
                             input int budget, input logic calm);
        int hold;
        drain_words();
        set_config(deb, blink, breathe, stp);
        steady = calm;
        phase_ticks = 0;
        while (phase_ticks < budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
                hold = (deb > 20) ? $urandom_range(1, 20)
                                  : int'(deb) + 1 + $urandom_range(0, 3);
                send_run(1'b0, hold);
                repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
                hold = (deb > 20) ? $urandom_range(1, 20)
                                  : int'(deb) + 1 + $urandom_range(0, 3);
                send_run(1'b1, hold);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEBOUNCE_TICKS;
        cfg_wdata = '0;
        tick_ch.valid = 1'b0;
        tick_ch.button_level = 1'b1;
        steady = 1'b0;
        phase_ticks = 0;
        tracker = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk through every mode with the shortest debounce and intervals,
        // then finish with a single-sample glitch that must be ignored.
        set_config(16'd0, 16'd1, 16'd1, 8'd255);
        for (int i = 21; i >= 0; i--) send_tick(PRESS_SCRIPT[i]);

        run_phase(16'd3, 16'd4, 16'd2, 8'd37, 140, 1'b0);
        run_phase(16'd1, 16'd65535, 16'd65535, 8'd1, 100, 1'b0);
        run_phase(16'd65534, 16'd2, 16'd1, 8'd200, 50, 1'b0);
        run_phase(cfg_data_t'($urandom_range(0, 4)), cfg_data_t'($urandom_range(1, 10)),
                  cfg_data_t'($urandom_range(1, 5)), step_t'($urandom_range(1, 255)),
                  150, 1'b1);
        run_phase(16'd0, 16'd1, 16'd1, 8'd255, 120, 1'b0);
        run_phase(RST_DEBOUNCE_TICKS, RST_BLINK_HALF_TICKS, RST_BREATHE_INTERVAL,
                  RST_BREATHE_STEP, 140, 1'b0);

        drain_words();
        repeat (4) @(posedge clk);
        tracker.mismatches += tracker.words_due.size();
        if (tracker.mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/dlmc_pkg.sv
hw/rtl/dlmc_if.sv
hw/rtl/debounced_led_mode_controller_top.sv
tb/sv/tb_debounced_led_mode_controller_top.sv
